/* rtl/nlpsc_pkg.sv */
`timescale 1ns / 1ps

package nlpsc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam logic [31:0] LEN_SAT = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam logic [2:0] SIZE_RESET = 3'd4;
    localparam logic [2:0] SIZE_MIN   = 3'd1;
    localparam logic [2:0] SIZE_MAX   = 3'd4;

    localparam int SC_LEN = 4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic REG_NAL_LENGTH_SIZE = 1'b0;

    typedef enum logic [1:0]
    {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed
    {
        logic [7:0] in_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    typedef struct packed
    {
        logic       has_sc;
        logic       has_data;
        logic [7:0] data_byte;
        logic       has_mark;
        logic       mark_ok;
    } cmd_t;

endpackage

/* rtl/nlpsc_front.sv */
`timescale 1ns / 1ps

module nlpsc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nlpsc_pkg::in_item_t in_data,
    input  logic [2:0]         nal_length_size,
    input  logic               q_full,
    output logic               push,
    output nlpsc_pkg::cmd_t    cmd
);

    logic                              phase_reg, phase_next;
    logic [2:0]                        prefix_count_reg, prefix_count_next;
    logic [31:0]                       length_accum_reg, length_accum_next;
    logic [nlpsc_pkg::COUNT_WIDTH-1:0] payload_left_reg, payload_left_next;

    logic                              accept;
    logic [2:0]                        eff_size;
    logic [31:0]                       acc;
    logic [31:0]                       len_sat;
    logic [2:0]                        cnt;
    logic [nlpsc_pkg::COUNT_WIDTH-1:0] left_dec;
    logic                              ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        if (nal_length_size < nlpsc_pkg::SIZE_MIN)
        begin
            eff_size = nlpsc_pkg::SIZE_MIN;
        end
        else if (nal_length_size > nlpsc_pkg::SIZE_MAX)
        begin
            eff_size = nlpsc_pkg::SIZE_MAX;
        end
        else
        begin
            eff_size = nal_length_size;
        end
    end

    assign acc      = {length_accum_reg[23:0], in_data.in_byte};
    assign cnt      = prefix_count_reg + 3'd1;
    assign len_sat  = (acc > nlpsc_pkg::LEN_SAT) ? nlpsc_pkg::LEN_SAT : acc;
    assign left_dec = payload_left_reg
                    - nlpsc_pkg::COUNT_WIDTH'(payload_left_reg != '0);

    always_comb
    begin
        phase_next        = phase_reg;
        prefix_count_next = prefix_count_reg;
        length_accum_next = length_accum_reg;
        payload_left_next = payload_left_reg;
        ok                = 1'b0;
        cmd               = '0;
        cmd.data_byte     = in_data.in_byte;

        if (!phase_reg)
        begin
            if (cnt >= eff_size)
            begin
                prefix_count_next = 3'd0;
                length_accum_next = 32'd0;
                if (acc == 32'd0)
                begin
                    ok = 1'b1;
                end
                else
                begin
                    payload_left_next = nlpsc_pkg::COUNT_WIDTH'(len_sat);
                    phase_next        = 1'b1;
                    cmd.has_sc        = 1'b1;
                end
            end
            else
            begin
                prefix_count_next = cnt;
                length_accum_next = acc;
            end
        end
        else
        begin
            cmd.has_data      = 1'b1;
            payload_left_next = left_dec;
            if (left_dec == '0)
            begin
                phase_next = 1'b0;
                ok         = 1'b1;
            end
        end

        if (in_data.frame_last)
        begin
            cmd.has_mark      = 1'b1;
            cmd.mark_ok       = ok;
            phase_next        = 1'b0;
            prefix_count_next = 3'd0;
            length_accum_next = 32'd0;
            payload_left_next = '0;
        end
    end

    assign push = accept && (cmd.has_sc || cmd.has_data || cmd.has_mark);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= 1'b0;
            prefix_count_reg <= 3'd0;
            length_accum_reg <= 32'd0;
            payload_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            prefix_count_reg <= prefix_count_next;
            length_accum_reg <= length_accum_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

/* rtl/nlpsc_queue.sv */
`timescale 1ns / 1ps

module nlpsc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nlpsc_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output nlpsc_pkg::cmd_t head_cmd
);

    nlpsc_pkg::cmd_t                 slot_reg [nlpsc_pkg::QDEPTH];
    logic [nlpsc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [nlpsc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [nlpsc_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == nlpsc_pkg::QCNT_W'(nlpsc_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + nlpsc_pkg::QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + nlpsc_pkg::QPTR_W'(pop);
        count_next  = count_reg + nlpsc_pkg::QCNT_W'(push)
                    - nlpsc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/nlpsc_back.sv */
`timescale 1ns / 1ps

module nlpsc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  nlpsc_pkg::cmd_t      head_cmd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output nlpsc_pkg::out_item_t out_data
);

    logic [2:0]           pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    nlpsc_pkg::out_item_t out_data_reg;
    nlpsc_pkg::out_item_t result;
    logic [2:0]           n_res;
    logic                 load;
    logic                 is_last;

    assign load = head_valid && (!out_valid_reg || !out_stall);

    assign n_res = (head_cmd.has_sc ? 3'(nlpsc_pkg::SC_LEN) : 3'd0)
                 + 3'(head_cmd.has_data) + 3'(head_cmd.has_mark);
    assign is_last = (pos_reg == n_res - 3'd1);

    always_comb
    begin
        result.run_last = is_last;
        if (head_cmd.has_sc && (pos_reg < 3'(nlpsc_pkg::SC_LEN)))
        begin
            result.kind     = nlpsc_pkg::KIND_DATA;
            result.out_byte = (pos_reg == 3'(nlpsc_pkg::SC_LEN - 1)) ? 8'h01 : 8'h00;
        end
        else if (head_cmd.has_data && (pos_reg == 3'd0))
        begin
            result.kind     = nlpsc_pkg::KIND_DATA;
            result.out_byte = head_cmd.data_byte;
        end
        else
        begin
            result.kind     = head_cmd.mark_ok ? nlpsc_pkg::KIND_OK : nlpsc_pkg::KIND_BAD;
            result.out_byte = 8'h00;
        end
    end

    assign pop = load && is_last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            pos_next       = is_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/nal_length_prefix_to_start_code_top.sv */
`timescale 1ns / 1ps

// length-prefixed (avcc) to start-code (annex b) converter. the input side takes one
// byte per cycle whenever the four-entry command queue has room; each accepted byte
// becomes at most one queue command. the output side drains one result per cycle from
// its output register while out_stall is low; a payload byte gives one result, a
// completed nonzero length prefix four (the 00 00 00 01 start code) and a frame end
// adds one marker. a frame that ends with kind malformed must be discarded downstream.
// nal_length_size (address 0) must be written only while the block is idle (unchecked).

module nal_length_prefix_to_start_code_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  nlpsc_pkg::in_item_t             in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output nlpsc_pkg::out_item_t            out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nlpsc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [2:0]      nal_length_size_reg;
    logic            cfg_write;
    logic            q_full;
    logic            push;
    logic            pop;
    logic            head_valid;
    nlpsc_pkg::cmd_t push_cmd;
    nlpsc_pkg::cmd_t head_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nal_length_size_reg <= nlpsc_pkg::SIZE_RESET;
        end
        else if (cfg_write && (paddr[2] == nlpsc_pkg::REG_NAL_LENGTH_SIZE))
        begin
            nal_length_size_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == nlpsc_pkg::REG_NAL_LENGTH_SIZE)
                  ? {29'd0, nal_length_size_reg} : 32'd0;

    nlpsc_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .nal_length_size (nal_length_size_reg),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd)
    );

    nlpsc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    nlpsc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

/* rtl/nlpsc_checker.sv */
`timescale 1ns / 1ps

module nlpsc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input nlpsc_pkg::out_item_t          out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // frame-end marker closes the run of its transaction
    a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != nlpsc_pkg::KIND_DATA) |-> out_data.run_last)
        else $error("frame-end marker without run_last");

    // frame-end marker carries a zero byte
    a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != nlpsc_pkg::KIND_DATA) |-> out_data.out_byte == 8'h00)
        else $error("frame-end marker with nonzero byte");

    // no result while in reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind nal_length_prefix_to_start_code_top nlpsc_checker u_checker (.*);
